FILE: rtl/pdls_pkg.sv
// pdls_pkg: shared types, codes and constants of the PD line-follow steering block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pdls_pkg;

  // operand width of the shared multiplier (product is twice as wide)
  localparam int unsigned PDLS_MUL_W = 26;

  typedef struct packed {
    logic [6:0] line_position;
    logic [7:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [12:0] left_drive;
    logic [12:0] right_drive;
    logic [1:0]  drive_mode;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_RUN   = 2'd0,
    MODE_BRAKE = 2'd1,
    MODE_STOP  = 2'd2
  } drive_mode_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CALC,
    FSM_DONE
  } fsm_e;

  // micro-steps of the sequencer, one multiply issued per step
  typedef enum logic [3:0] {
    STEP_KP_S,   // kp * s
    STEP_KP_E,   // (kp*s) * e
    STEP_KD_S,   // kd * s, latch proportional part
    STEP_KD_D,   // (kd*s) * d
    STEP_S_DIV,  // s / 100, add derivative part
    STEP_T0_S,   // t * s
    STEP_T0_DIV, // / 100
    STEP_T1_S,
    STEP_T1_DIV,
    STEP_T2_S,
    STEP_T2_DIV,
    STEP_Q_DIV,  // t / 50 as 2t / 100
    STEP_SUMS    // form both drive sums
  } step_e;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_DERIV_GAIN = 2'd1;
  localparam logic [1:0] REG_MAX_SPEED  = 2'd2;

  localparam logic [9:0]  PROP_GAIN_RST  = 10'd70;
  localparam logic [10:0] DERIV_GAIN_RST = 11'd819;
  localparam logic [9:0]  MAX_SPEED_RST  = 10'd600;

  localparam logic [7:0]  KEY_BRAKE   = 8'd152;
  localparam logic [7:0]  KEY_RESUME  = 8'd24;
  localparam logic [12:0] DRIVE_MAX   = 13'd6800;
  localparam logic [12:0] DRIVE_MIN   = 13'd10;
  localparam logic [6:0]  POS_LOW     = 7'd4;
  localparam logic [6:0]  POS_HIGH    = 7'd124;
  localparam logic [6:0]  POS_CENTRE  = 7'd64;
  localparam logic [9:0]  SPEED_STEP  = 10'd4;
  localparam logic [9:0]  STOP_LIMIT  = 10'd104;

  // floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 6M
  localparam logic [21:0] RECIP_100   = 22'd2684355;
  localparam int unsigned RECIP_SHIFT = 28;

  function automatic logic [12:0] clamp_drive(input logic signed [31:0] v);
    logic [12:0] r;
    if (v > $signed({19'd0, DRIVE_MAX})) begin
      r = DRIVE_MAX;
    end else if (v < $signed({19'd0, DRIVE_MIN})) begin
      r = DRIVE_MIN;
    end else begin
      r = v[12:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pdls_mul.sv
// pdls_mul: shared signed multiplier with registered product.
// Depends on pdls_pkg for the default operand width.
`timescale 1ns / 1ps
`default_nettype none

module pdls_mul
  import pdls_pkg::*;
#(
  parameter int unsigned MulW = PDLS_MUL_W
) (
  input  wire logic                       clk_i,
  input  wire logic signed [MulW-1:0]     a_i,
  input  wire logic signed [MulW-1:0]     b_i,
  output logic signed      [2*MulW-1:0]   p_o
);

  logic signed [2*MulW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/pd_line_follow_steering.sv
// pd_line_follow_steering: PD differential steering with speed ramp and brake/stop modes.
// Depends on pdls_pkg and pdls_mul (shared multiplier).
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_valid_i/in_ready_o/in_data_i): one transfer per control tick,
//   carrying the line position (centre 64) and the remote key code.
//   Output channel (out_valid_o/out_ready_i/out_data_o): one transfer per input,
//   left/right drive (10..6800, 0 when stopped) and the mode after the tick.
//   APB port: kp (0x0), kd (0x4), max speed (0x8); write only while idle.
// Timing
//   All products go through one registered multiplier under a 13-step
//   sequencer: kp*s*e, kd*s*d, then the quartic speed term as s / 100,
//   three multiply / divide-by-100 pairs and a final divide by 50
//   (division by reciprocal multiply). The result is written to the output
//   register from the done state; the next input is taken only back in idle.
//   in_ready_o is low while an item is in the sequencer.
// Stall
//   A finished item waits in the sequencer until the output register is free;
//   the output register holds its item until out_ready_i.
// Reset
//   Gains and max speed go to 70, 819, 600; speed 0, run mode, last position
//   64, held drives 0. No memory, so no clearing pass.
module pd_line_follow_steering
  import pdls_pkg::*;
#(
  parameter int unsigned MulW = PDLS_MUL_W
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [9:0]  kp_q;
  logic [10:0] kd_q;
  logic [9:0]  max_speed_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= PROP_GAIN_RST;
      kd_q        <= DERIV_GAIN_RST;
      max_speed_q <= MAX_SPEED_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PROP_GAIN:  kp_q        <= pwdata[9:0];
        REG_DERIV_GAIN: kd_q        <= pwdata[10:0];
        REG_MAX_SPEED:  max_speed_q <= pwdata[9:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PROP_GAIN:  prdata = {22'd0, kp_q};
      REG_DERIV_GAIN: prdata = {21'd0, kd_q};
      REG_MAX_SPEED:  prdata = {22'd0, max_speed_q};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  fsm_e        state_q, state_d;
  step_e       step_q, step_d;
  drive_mode_e mode_q, mode_d;
  logic [9:0]  speed_q, speed_d;
  logic [6:0]  last_pos_q, last_pos_d;
  logic [12:0] held_l_q, held_l_d;
  logic [12:0] held_r_q, held_r_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;

  // latched input item and datapath registers
  in_item_t           item_q;
  logic signed [31:0] corr_q;
  logic signed [31:0] sum_l_q;
  logic signed [31:0] sum_r_q;
  logic [7:0]         quart_q;

  logic in_fire;
  logic done_fire;
  logic calc_en;

  assign in_fire   = in_valid_i & in_ready_o;
  assign done_fire = (state_q == FSM_DONE) & (~out_valid_q | out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (in_valid_i)              state_d = FSM_CALC;
      FSM_CALC: if (step_q == STEP_SUMS)     state_d = FSM_DONE;
      FSM_DONE: if (~out_valid_q | out_ready_i) state_d = FSM_IDLE;
      default:                               state_d = FSM_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    calc_en    = 1'b0;
    case (state_q)
      FSM_IDLE: in_ready_o = 1'b1;
      FSM_CALC: calc_en    = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (in_fire) begin
      step_d = STEP_KP_S;
    end else if (calc_en && step_q != STEP_SUMS) begin
      step_d = step_e'(step_q + 4'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier and operand select
  // ---------------------------------------------------------------------------
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [2*MulW-1:0] prod;
  logic signed [7:0]        err;     // pos - 64
  logic signed [7:0]        dlt;     // pos - last pos
  logic signed [MulW-1:0]   op_s, op_recip, op_quo, op_low;

  assign err = $signed({1'b0, item_q.line_position}) - $signed({1'b0, POS_CENTRE});
  assign dlt = $signed({1'b0, item_q.line_position}) - $signed({1'b0, last_pos_q});

  assign op_s     = $signed({{(MulW-10){1'b0}}, speed_q});
  assign op_recip = $signed({{(MulW-22){1'b0}}, RECIP_100});
  // quotient of the previous reciprocal multiply
  assign op_quo   = $signed({{(MulW-22){1'b0}}, prod[RECIP_SHIFT +: 22]});
  assign op_low   = prod[MulW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      STEP_KP_S: begin
        mul_a = $signed({{(MulW-10){1'b0}}, kp_q});
        mul_b = op_s;
      end
      STEP_KP_E: begin
        mul_a = op_low;
        mul_b = $signed({{(MulW-8){err[7]}}, err});
      end
      STEP_KD_S: begin
        mul_a = $signed({{(MulW-11){1'b0}}, kd_q});
        mul_b = op_s;
      end
      STEP_KD_D: begin
        mul_a = op_low;
        mul_b = $signed({{(MulW-8){dlt[7]}}, dlt});
      end
      STEP_S_DIV, STEP_T0_DIV, STEP_T1_DIV, STEP_T2_DIV: begin
        mul_a = (step_q == STEP_S_DIV) ? op_s : op_low;
        mul_b = op_recip;
      end
      STEP_T0_S, STEP_T1_S, STEP_T2_S: begin
        mul_a = op_quo;
        mul_b = op_s;
      end
      STEP_Q_DIV: begin
        // t / 50 computed as (2t) / 100
        mul_a = $signed({{(MulW-22){1'b0}}, prod[RECIP_SHIFT +: 21], 1'b0});
        mul_b = op_recip;
      end
      default: ;
    endcase
  end

  pdls_mul #(
    .MulW (MulW)
  ) u_pdls_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  logic signed [31:0] base;
  assign base = $signed({11'd0, speed_q, 11'd0});  // 2048 * s

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (calc_en) begin
      case (step_q)
        STEP_KD_S:  corr_q <= prod[31:0];
        STEP_S_DIV: corr_q <= corr_q + prod[31:0];
        STEP_SUMS: begin
          sum_l_q <= base + corr_q;
          sum_r_q <= base - corr_q;
          quart_q <= prod[RECIP_SHIFT +: 8];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tick commit: drives, speed ramp and mode
  // ---------------------------------------------------------------------------
  logic signed [31:0] l_raw, r_raw;
  logic [12:0]        l_new, r_new;
  logic               pos_ok;
  logic [10:0]        speed_inc;

  assign l_raw  = (sum_l_q >>> 8) + $signed({24'd0, quart_q});
  assign r_raw  = sum_r_q >>> 8;
  assign pos_ok = (item_q.line_position >= POS_LOW) && (item_q.line_position <= POS_HIGH);
  assign l_new  = pos_ok ? clamp_drive(l_raw) : clamp_drive($signed({19'd0, held_l_q}));
  assign r_new  = pos_ok ? clamp_drive(r_raw) : clamp_drive($signed({19'd0, held_r_q}));
  assign speed_inc = {1'b0, speed_q} + {1'b0, SPEED_STEP};

  always_comb begin
    mode_d     = mode_q;
    speed_d    = speed_q;
    last_pos_d = last_pos_q;
    held_l_d   = held_l_q;
    held_r_d   = held_r_q;
    out_data_d = '0;
    case (mode_q)
      MODE_RUN: begin
        held_l_d   = l_new;
        held_r_d   = r_new;
        last_pos_d = item_q.line_position;
        speed_d    = (speed_inc > {1'b0, max_speed_q}) ? max_speed_q : speed_inc[9:0];
        if (item_q.key_code == KEY_BRAKE) begin
          mode_d = MODE_BRAKE;
        end
        out_data_d.left_drive  = l_new;
        out_data_d.right_drive = r_new;
      end
      MODE_BRAKE: begin
        held_l_d   = l_new;
        held_r_d   = r_new;
        last_pos_d = item_q.line_position;
        speed_d    = (speed_q >= SPEED_STEP) ? (speed_q - SPEED_STEP) : 10'd0;
        if (speed_q < STOP_LIMIT) begin
          mode_d = MODE_STOP;
        end
        out_data_d.left_drive  = l_new;
        out_data_d.right_drive = r_new;
      end
      default: begin
        // stopped: zero drive, resume key restarts the ramp from zero
        mode_d = MODE_STOP;
        if (item_q.key_code == KEY_RESUME) begin
          speed_d = 10'd0;
          mode_d  = MODE_RUN;
        end
      end
    endcase
    out_data_d.drive_mode = mode_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      step_q      <= STEP_KP_S;
      mode_q      <= MODE_RUN;
      speed_q     <= 10'd0;
      last_pos_q  <= POS_CENTRE;
      held_l_q    <= 13'd0;
      held_r_q    <= 13'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (done_fire) begin
        mode_q     <= mode_d;
        speed_q    <= speed_d;
        last_pos_q <= last_pos_d;
        held_l_q   <= held_l_d;
        held_r_q   <= held_r_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/pdls_checker.sv
// pdls_checker: port-level assertions for pd_line_follow_steering, bound to the top level.
// Depends on pdls_pkg for the item types and mode codes.
`timescale 1ns / 1ps
`default_nettype none

module pdls_checker
  import pdls_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("pdls: stalled result changed");

  // one item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("pdls: input taken while busy");

  // drives are zero together or both inside the clamp range
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.left_drive == 13'd0) == (out_data_o.right_drive == 13'd0))
      && (out_data_o.left_drive == 13'd0 ||
          (out_data_o.left_drive >= DRIVE_MIN && out_data_o.left_drive <= DRIVE_MAX))
      && (out_data_o.right_drive == 13'd0 ||
          (out_data_o.right_drive >= DRIVE_MIN && out_data_o.right_drive <= DRIVE_MAX)))
    else $error("pdls: drive outside clamp range");

  // a braking tick always drives
  a_brake_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.drive_mode == MODE_BRAKE |-> out_data_o.left_drive != 13'd0)
    else $error("pdls: zero drive while braking");

  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.drive_mode == MODE_RUN ||
                     out_data_o.drive_mode == MODE_BRAKE ||
                     out_data_o.drive_mode == MODE_STOP))
    else $error("pdls: bad mode code");

endmodule

bind pd_line_follow_steering pdls_checker u_pdls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
